// ----- rtl/core/rlz_factor_window_expander_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the RLZ factor window expander
// Each macro checks one implication on the rising edge of clk and is held off
// while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RLZ_FACTOR_WINDOW_EXPANDER_DEFINES_SVH
`define RLZ_FACTOR_WINDOW_EXPANDER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RLZFWE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RLZFWE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rlzfwe_pkg.sv -----
// ----------------------------------------------------------------------------
// rlzfwe_pkg
// Shared types, codes and widths of the RLZ factor window expander.
// ----------------------------------------------------------------------------
`default_nettype none

package rlzfwe_pkg;

  // Default sizes of the reference store and of one factor.
  localparam int REF_DEPTH_DEF      = 1048576;
  localparam int MAX_FACTOR_LEN_DEF = 64;

  // Stream payload widths.
  localparam int IN_TDATA_W  = 136;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Field widths that the datapath uses.
  localparam int BLOCK_SIZE_W = 21;
  localparam int POS_W        = 32;
  localparam int REF_ADDR_W   = 20;
  localparam int LEN_W        = 7;
  localparam int BLK_IDX_W    = 16;
  // Reference address plus copy offset before the depth reduction.
  localparam int MOD_VAL_W    = 21;

  localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RESET = 21'd1024;

  // Request kinds carried in in_tuser.
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_BEGIN  = 2'd1,
    OP_FACTOR = 2'd2,
    OP_END    = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_SIZE = 1'd0,
    REG_TEXT_SIZE  = 1'd1
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POS,
    ST_OFS,
    ST_MOD,
    ST_RD,
    ST_EMIT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/rlzfwe_ram.sv -----
// ----------------------------------------------------------------------------
// rlzfwe_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rlzfwe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data is registered and holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rlz_factor_window_expander.sv -----
// ----------------------------------------------------------------------------
// rlz_factor_window_expander
// Expands relative Lempel-Ziv factors against a stored reference text and
// streams out only the characters that fall inside a requested window.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   in_     | slave     | in_tvalid/in_tready  | in_tdata fields, in_tuser opcode
//   out_    | master    | out_tvalid/out_tready| out_tdata, out_tuser, out_tlast
//   cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A load request runs the MOD_STEPS shift-subtract steps reducing an address by
// REF_DEPTH (1 at the default). An end request, or a begin request whose window
// starts at or past the text size, places a done result. A factor runs ST_POS,
// ST_OFS, the MOD_STEPS steps and ST_RD, then emits one character per cycle
// while the output is not stalled, set by the single read port of the reference
// RAM; one that falls before the window or copies nothing ends after ST_OFS.
// A stalled output holds the sequencer; reset is synchronous, active low, and
// needs no clearing pass since the reference store is undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module rlz_factor_window_expander #(
  parameter int REF_DEPTH      = rlzfwe_pkg::REF_DEPTH_DEF,
  parameter int MAX_FACTOR_LEN = rlzfwe_pkg::MAX_FACTOR_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0: ref_addr(20), ref_byte(8), window_start(32),
  // window_length(32), factor_pos(20), factor_len(7), new_block(1),
  // block_index(16).
  input  logic [rlzfwe_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Fields from bit 0: opcode(2).
  input  logic [rlzfwe_pkg::IN_TUSER_W-1:0]   in_tuser,
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0: out_char(8), copied_total(32).
  output logic [rlzfwe_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // Fields from bit 0: char_valid(1), done_res(1).
  output logic [rlzfwe_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                                out_tlast,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rlzfwe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rlzfwe_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW        = $clog2(REF_DEPTH);
  localparam int MVW       = rlzfwe_pkg::MOD_VAL_W;
  localparam int PW        = rlzfwe_pkg::POS_W;
  localparam int LW        = rlzfwe_pkg::LEN_W;
  localparam int BW        = rlzfwe_pkg::BLOCK_SIZE_W;
  localparam int IW        = rlzfwe_pkg::BLK_IDX_W;
  localparam int ADDR_SPAN = 2 ** MVW;
  // Steps needed so that REF_DEPTH shifted by the step count exceeds any address.
  localparam int MOD_STEPS = (REF_DEPTH >= ADDR_SPAN) ? 0 :
                             $clog2((ADDR_SPAN + REF_DEPTH - 1) / REF_DEPTH);
  localparam int MOD_INIT  = (MOD_STEPS == 0) ? 0 : REF_DEPTH * (2 ** (MOD_STEPS - 1));
  localparam int MCW       = $clog2(MOD_STEPS + 1) + 1;

  localparam logic [AW-1:0]  ADDR_LAST = AW'(REF_DEPTH - 1);
  localparam logic [LW-1:0]  MAX_LEN   = LW'(MAX_FACTOR_LEN);
  localparam logic [MVW-1:0] DSUB_INIT = MVW'(MOD_INIT);
  localparam logic [MCW-1:0] CNT_INIT  = MCW'(MOD_STEPS);

  // Input field slices.
  rlzfwe_pkg::op_t     in_op;
  logic [rlzfwe_pkg::REF_ADDR_W-1:0] in_ref_addr;
  logic [7:0]          in_ref_byte;
  logic [PW-1:0]       in_win_start;
  logic [PW-1:0]       in_win_len;
  logic [rlzfwe_pkg::REF_ADDR_W-1:0] in_fpos;
  logic [LW-1:0]       in_flen;
  logic                in_new_block;
  logic [IW-1:0]       in_blk_idx;

  assign in_op        = rlzfwe_pkg::op_t'(in_tuser);
  assign in_ref_addr  = in_tdata[19:0];
  assign in_ref_byte  = in_tdata[27:20];
  assign in_win_start = in_tdata[59:28];
  assign in_win_len   = in_tdata[91:60];
  assign in_fpos      = in_tdata[111:92];
  assign in_flen      = in_tdata[118:112];
  assign in_new_block = in_tdata[119];
  assign in_blk_idx   = in_tdata[135:120];

  // Control and window state.
  rlzfwe_pkg::state_t state_r, state_nxt;
  logic [BW-1:0]  block_size_r, block_size_nxt;
  logic [PW-1:0]  text_size_r, text_size_nxt;
  logic [PW-1:0]  running_r, running_nxt;
  logic [PW-1:0]  wb_r, wb_nxt;
  logic [PW-1:0]  remaining_r, remaining_nxt;
  logic [PW-1:0]  copied_r, copied_nxt;
  logic           started_r, started_nxt;
  logic           active_r, active_nxt;
  logic           out_valid_r, out_valid_nxt;

  // Per-request working registers.
  logic [rlzfwe_pkg::REF_ADDR_W-1:0] fpos_r, fpos_nxt;
  logic [LW-1:0]  flen_r, flen_nxt;
  logic           nb_r, nb_nxt;
  logic [PW-1:0]  prod_r, prod_nxt;
  logic [PW-1:0]  prior_r, prior_nxt;
  logic [LW-1:0]  copy_left_r, copy_left_nxt;
  logic           close_r, close_nxt;
  logic           load_r, load_nxt;
  logic [7:0]     wdata_r, wdata_nxt;
  logic [MVW-1:0] mod_val_r, mod_val_nxt;
  logic [MVW-1:0] dsub_r, dsub_nxt;
  logic [MCW-1:0] mod_cnt_r, mod_cnt_nxt;
  logic [AW-1:0]  addr_r, addr_nxt;

  // Result register.
  logic [7:0]     out_char_r, out_char_nxt;
  logic           out_cv_r, out_cv_nxt;
  logic           out_last_r, out_last_nxt;
  logic           out_done_r, out_done_nxt;
  logic [PW-1:0]  out_total_r, out_total_nxt;

  // Reference RAM interface.
  logic           ram_we;
  logic           ram_re;
  logic [7:0]     ram_rdata;

  // Combinational helpers.
  logic           slot_free;
  logic [BW+IW-1:0] prod_full;
  logic [PW-1:0]  prior;
  logic [PW-1:0]  gap;
  logic [LW-1:0]  offset;
  logic [LW-1:0]  avail;
  logic [LW-1:0]  copy;
  logic [AW-1:0]  addr_inc;

  assign slot_free = !out_valid_r || out_tready;
  assign prod_full = in_blk_idx * block_size_r;
  assign prior     = nb_r ? prod_r : running_r;
  assign addr_inc  = (addr_r == ADDR_LAST) ? '0 : addr_r + 1'b1;

  // Copy window of the current factor.
  always_comb begin
    gap = wb_r - prior_r;
    if (started_r || !(prior_r < wb_r)) begin
      offset = '0;
    end else if (gap > PW'(flen_r)) begin
      offset = flen_r;
    end else begin
      offset = gap[LW-1:0];
    end
    avail = flen_r - offset;
    copy  = (remaining_r < PW'(avail)) ? remaining_r[LW-1:0] : avail;
  end

  // Reference text store.
  rlzfwe_ram #(
    .WIDTH(8),
    .DEPTH(REF_DEPTH)
  ) u_ref_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(mod_val_r)),
    .wdata(wdata_r),
    .re   (ram_re),
    .raddr(addr_r),
    .rdata(ram_rdata)
  );

  // Sequencer: next state, datapath updates and RAM strobes.
  always_comb begin
    state_nxt      = state_r;
    block_size_nxt = block_size_r;
    text_size_nxt  = text_size_r;
    running_nxt    = running_r;
    wb_nxt         = wb_r;
    remaining_nxt  = remaining_r;
    copied_nxt     = copied_r;
    started_nxt    = started_r;
    active_nxt     = active_r;
    fpos_nxt       = fpos_r;
    flen_nxt       = flen_r;
    nb_nxt         = nb_r;
    prod_nxt       = prod_r;
    prior_nxt      = prior_r;
    copy_left_nxt  = copy_left_r;
    close_nxt      = close_r;
    load_nxt       = load_r;
    wdata_nxt      = wdata_r;
    mod_val_nxt    = mod_val_r;
    dsub_nxt       = dsub_r;
    mod_cnt_nxt    = mod_cnt_r;
    addr_nxt       = addr_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_char_nxt   = out_char_r;
    out_cv_nxt     = out_cv_r;
    out_last_nxt   = out_last_r;
    out_done_nxt   = out_done_r;
    out_total_nxt  = out_total_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    in_tready      = (state_r == rlzfwe_pkg::ST_IDLE);

    // Configuration writes are to arrive only while the block is idle; the block itself does not enforce this.
    if (cfg_valid) begin
      case (cfg_index)
        rlzfwe_pkg::REG_BLOCK_SIZE: block_size_nxt = cfg_data[BW-1:0];
        rlzfwe_pkg::REG_TEXT_SIZE:  text_size_nxt  = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      rlzfwe_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          case (in_op)
            rlzfwe_pkg::OP_LOAD: begin
              wdata_nxt   = in_ref_byte;
              mod_val_nxt = MVW'(in_ref_addr);
              dsub_nxt    = DSUB_INIT;
              mod_cnt_nxt = CNT_INIT;
              load_nxt    = 1'b1;
              state_nxt   = rlzfwe_pkg::ST_MOD;
            end
            rlzfwe_pkg::OP_BEGIN: begin
              copied_nxt  = '0;
              started_nxt = 1'b0;
              running_nxt = '0;
              if (in_win_start >= text_size_r) begin
                active_nxt    = 1'b0;
                remaining_nxt = '0;
                state_nxt     = rlzfwe_pkg::ST_DONE;
              end else begin
                active_nxt    = 1'b1;
                wb_nxt        = in_win_start;
                remaining_nxt = in_win_len;
              end
            end
            rlzfwe_pkg::OP_FACTOR: begin
              if (active_r) begin
                fpos_nxt  = in_fpos;
                flen_nxt  = (in_flen > MAX_LEN) ? MAX_LEN : in_flen;
                nb_nxt    = in_new_block;
                prod_nxt  = prod_full[PW-1:0];
                state_nxt = rlzfwe_pkg::ST_POS;
              end
            end
            rlzfwe_pkg::OP_END: begin
              active_nxt = 1'b0;
              state_nxt  = rlzfwe_pkg::ST_DONE;
            end
            default: ;
          endcase
        end
      end

      // Advance the running text position past this factor.
      rlzfwe_pkg::ST_POS: begin
        prior_nxt   = prior;
        running_nxt = prior + PW'(flen_r);
        state_nxt   = rlzfwe_pkg::ST_OFS;
      end

      // Decide how many characters of the factor fall into the window.
      rlzfwe_pkg::ST_OFS: begin
        if (running_r < wb_r) begin
          state_nxt = rlzfwe_pkg::ST_IDLE;
        end else begin
          started_nxt   = 1'b1;
          remaining_nxt = remaining_r - PW'(copy);
          copy_left_nxt = copy;
          close_nxt     = (remaining_r == PW'(copy));
          if (remaining_r == PW'(copy)) begin
            active_nxt = 1'b0;
          end
          mod_val_nxt = MVW'(fpos_r) + MVW'(offset);
          dsub_nxt    = DSUB_INIT;
          mod_cnt_nxt = CNT_INIT;
          load_nxt    = 1'b0;
          if (copy != '0) begin
            state_nxt = rlzfwe_pkg::ST_MOD;
          end else if (remaining_r == PW'(copy)) begin
            state_nxt = rlzfwe_pkg::ST_DONE;
          end else begin
            state_nxt = rlzfwe_pkg::ST_IDLE;
          end
        end
      end

      // Reduce the address by the reference depth, one shift-subtract a cycle.
      rlzfwe_pkg::ST_MOD: begin
        if (mod_cnt_r == '0) begin
          if (load_r) begin
            ram_we    = 1'b1;
            state_nxt = rlzfwe_pkg::ST_IDLE;
          end else begin
            addr_nxt  = AW'(mod_val_r);
            state_nxt = rlzfwe_pkg::ST_RD;
          end
        end else begin
          if (mod_val_r >= dsub_r) begin
            mod_val_nxt = mod_val_r - dsub_r;
          end
          dsub_nxt    = dsub_r >> 1;
          mod_cnt_nxt = mod_cnt_r - 1'b1;
        end
      end

      // First reference read of the copy.
      rlzfwe_pkg::ST_RD: begin
        ram_re    = 1'b1;
        addr_nxt  = addr_inc;
        state_nxt = rlzfwe_pkg::ST_EMIT;
      end

      // Hand one character to the result register and fetch the next one.
      rlzfwe_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ram_rdata;
          out_cv_nxt    = 1'b1;
          out_last_nxt  = (copy_left_r == LW'(1));
          out_done_nxt  = (copy_left_r == LW'(1)) && close_r;
          out_total_nxt = copied_r + 1'b1;
          copied_nxt    = copied_r + 1'b1;
          copy_left_nxt = copy_left_r - 1'b1;
          if (copy_left_r == LW'(1)) begin
            state_nxt = rlzfwe_pkg::ST_IDLE;
          end else begin
            ram_re   = 1'b1;
            addr_nxt = addr_inc;
          end
        end
      end

      // Result without a character: window finished or reported early.
      rlzfwe_pkg::ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = '0;
          out_cv_nxt    = 1'b0;
          out_last_nxt  = 1'b1;
          out_done_nxt  = 1'b1;
          out_total_nxt = copied_r;
          state_nxt     = rlzfwe_pkg::ST_IDLE;
        end
      end

      default: state_nxt = rlzfwe_pkg::ST_IDLE;
    endcase
  end

  // State register and control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rlzfwe_pkg::ST_IDLE;
      block_size_r <= rlzfwe_pkg::BLOCK_SIZE_RESET;
      text_size_r  <= '0;
      running_r    <= '0;
      wb_r         <= '0;
      remaining_r  <= '0;
      copied_r     <= '0;
      started_r    <= 1'b0;
      active_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      block_size_r <= block_size_nxt;
      text_size_r  <= text_size_nxt;
      running_r    <= running_nxt;
      wb_r         <= wb_nxt;
      remaining_r  <= remaining_nxt;
      copied_r     <= copied_nxt;
      started_r    <= started_nxt;
      active_r     <= active_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    fpos_r      <= fpos_nxt;
    flen_r      <= flen_nxt;
    nb_r        <= nb_nxt;
    prod_r      <= prod_nxt;
    prior_r     <= prior_nxt;
    copy_left_r <= copy_left_nxt;
    close_r     <= close_nxt;
    load_r      <= load_nxt;
    wdata_r     <= wdata_nxt;
    mod_val_r   <= mod_val_nxt;
    dsub_r      <= dsub_nxt;
    mod_cnt_r   <= mod_cnt_nxt;
    addr_r      <= addr_nxt;
    out_char_r  <= out_char_nxt;
    out_cv_r    <= out_cv_nxt;
    out_last_r  <= out_last_nxt;
    out_done_r  <= out_done_nxt;
    out_total_r <= out_total_nxt;
  end

  // Output ports.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_total_r, out_char_r};
  assign out_tuser  = {out_done_r, out_cv_r};
  assign out_tlast  = out_last_r;
  assign cfg_ready  = 1'b1;

endmodule

`default_nettype wire

// ----- rtl/core/rlzfwe_checker.sv -----
// ----------------------------------------------------------------------------
// rlzfwe_checker
// Port-level checks of the RLZ factor window expander, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rlz_factor_window_expander_defines.svh"

module rlzfwe_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [rlzfwe_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [rlzfwe_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [rlzfwe_pkg::OUT_TUSER_W-1:0] out_tuser,
  input logic                               out_tlast
);

  // A stalled result holds its whole payload.
  `RLZFWE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")

  // A finished window always closes the result burst of its request.
  `RLZFWE_ASSERT_NOW(a_done_last, out_tvalid && out_tuser[1], out_tlast, "done result without last")

  // A result without a character is a done marker with a zero character.
  `RLZFWE_ASSERT_NOW(a_empty_done, out_tvalid && !out_tuser[0], out_tuser[1] && out_tlast && (out_tdata[7:0] == 8'd0), "empty result is not a done marker")

  // A load request occupies the sequencer for at least the following cycle.
  `RLZFWE_ASSERT_NEXT(a_load_busy, in_tvalid && in_tready && (in_tuser == rlzfwe_pkg::OP_LOAD), !in_tready, "ready right after a load request")

endmodule

bind rlz_factor_window_expander rlzfwe_checker u_rlzfwe_checker (.*);

`default_nettype wire
